@@ hw/rtl/cordic_sine_cosine_unit_defines.svh @@
// Assertion macros shared by the checker file.
`ifndef CORDIC_SINE_COSINE_UNIT_DEFINES_SVH
`define CORDIC_SINE_COSINE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define CSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define CSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also covers reset itself.
`define CSC_ASSERT_RESET(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/csc_pkg.sv @@
`timescale 1ns / 1ps

package csc_pkg;

  localparam int ITERATIONS  = 10;
  localparam int DATA_W      = 16;
  localparam int MAX_STEPS   = 16;
  localparam int ANGLE_W     = 8;
  localparam int MAG_W       = 15;
  localparam int OUT_W       = 16;
  localparam int THETA_W     = 18;
  localparam int STEP_W      = $clog2(ITERATIONS);
  localparam int SHIFT_W     = STEP_W + 1;
  localparam int ANGLE_OFFSET = 45;
  localparam int ANGLE_FRAC  = 8;
  localparam logic [MAG_W-1:0] START_RESET = MAG_W'(10236);

  typedef logic signed [THETA_W-1:0] theta_t;
  typedef logic signed [DATA_W-1:0]  data_t;

  typedef struct packed {
    logic   valid;
    theta_t theta;
    data_t  x;
    data_t  y;
  } stage_t;

  localparam theta_t ATAN_TABLE [MAX_STEPS] = '{
    THETA_W'(6801), THETA_W'(3593), THETA_W'(1824), THETA_W'(916),
    THETA_W'(458),  THETA_W'(229),  THETA_W'(115),  THETA_W'(57),
    THETA_W'(29),   THETA_W'(14),   THETA_W'(7),    THETA_W'(4),
    THETA_W'(2),    THETA_W'(1),    THETA_W'(0),    THETA_W'(0)
  };

  function automatic theta_t atan_lookup(input logic [STEP_W-1:0] step);
    return ATAN_TABLE[step];
  endfunction

endpackage

@@ hw/rtl/cordic_sine_cosine_unit.sv @@
`timescale 1ns / 1ps
// Sine and cosine of an angle in whole degrees by rotation-mode CORDIC.
// Input channel: in_valid / in_ready carry angle_deg (0 to 255, meaningful
// about 0 to 90). Output channel: out_valid / out_ready carry sine and cosine,
// signed 16-bit values scaled by start_magnitude.
// config_write loads config_data into start_magnitude, the shared start value
// of x and y; write it only while no request is in flight.
// The datapath is a row of ten rotation cells, one micro-rotation per cell,
// each cell registering its result and passing it to the next one.
// Throughput: one request per cycle unless the row is stalled; each
// cell holds one request in flight.
// When the receiver stalls with a result waiting, the whole row holds and
// in_ready drops; while the last cell holds no result, in_ready stays high.
// Reset clears all valid flags and sets start_magnitude to 10236; the block
// takes a request in the first cycle after reset.

module cordic_sine_cosine_unit
  import csc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic        [ANGLE_W-1:0] angle_deg,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [OUT_W-1:0]   sine,
  output logic signed [OUT_W-1:0]   cosine,
  input  logic                      config_write,
  input  logic        [MAG_W-1:0]   config_data
);

  logic [MAG_W-1:0] start_magnitude;
  logic             advance;
  stage_t           feed;
  stage_t           chain [ITERATIONS+1];
  theta_t           theta_init;
  data_t            mag_init;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_magnitude <= START_RESET;
    end else if (config_write) begin
      start_magnitude <= config_data;
    end
  end

  assign advance    = !chain[ITERATIONS].valid || out_ready;
  assign in_ready   = advance;
  assign theta_init = (THETA_W'(angle_deg) - THETA_W'(ANGLE_OFFSET)) <<< ANGLE_FRAC;
  assign mag_init   = DATA_W'(start_magnitude);
  assign feed       = '{valid: in_valid, theta: theta_init, x: mag_init, y: mag_init};
  assign chain[0]   = feed;

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
    csc_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .step    (STEP_W'(i)),
      .prev    (chain[i]),
      .curr    (chain[i+1])
    );
  end

  assign out_valid = chain[ITERATIONS].valid;
  assign sine      = OUT_W'(chain[ITERATIONS].y);
  assign cosine    = OUT_W'(chain[ITERATIONS].x);

endmodule

@@ hw/rtl/csc_cell.sv @@
`timescale 1ns / 1ps

module csc_cell
  import csc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [STEP_W-1:0] step,
  input  stage_t            prev,
  output stage_t            curr
);

  logic               valid;
  theta_t             theta;
  data_t              x;
  data_t              y;
  logic [SHIFT_W-1:0] shamt;
  data_t              xs;
  data_t              ys;
  theta_t             theta_next;
  data_t              x_next;
  data_t              y_next;

  assign shamt = SHIFT_W'(step) + SHIFT_W'(1);
  assign xs    = prev.x >>> shamt;
  assign ys    = prev.y >>> shamt;

  always_comb begin
    if (prev.theta[THETA_W-1]) begin
      theta_next = prev.theta + atan_lookup(step);
      x_next     = prev.x + ys;
      y_next     = prev.y - xs;
    end else begin
      theta_next = prev.theta - atan_lookup(step);
      x_next     = prev.x - ys;
      y_next     = prev.y + xs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= prev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      theta <= theta_next;
      x     <= x_next;
      y     <= y_next;
    end
  end

  assign curr = '{valid: valid, theta: theta, x: x, y: y};

endmodule

@@ hw/rtl/csc_checker.sv @@
`timescale 1ns / 1ps
`include "cordic_sine_cosine_unit_defines.svh"

module csc_checker
  import csc_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic        [ANGLE_W-1:0] angle_deg,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [OUT_W-1:0]   sine,
  input logic signed [OUT_W-1:0]   cosine,
  input logic                      config_write,
  input logic        [MAG_W-1:0]   config_data
);

  `CSC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `CSC_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(sine) && $stable(cosine), "result changed while stalled")
  `CSC_ASSERT_NOW(a_stall_blocks, out_valid && !out_ready, !in_ready, "request taken into a stalled row")
  `CSC_ASSERT_NOW(a_empty_ready, !out_valid, in_ready, "row refused a request with no result waiting")
  `CSC_ASSERT_RESET(a_reset_clear, rst, !out_valid, "result shown after reset")

endmodule

bind cordic_sine_cosine_unit csc_checker u_csc_checker (.*);
